// ===== src/bsp_pkg.sv =====
// Package for the bitmap slot pool: payload structs, operation and status codes,
// and the control structs that pass between the front and back ends. No dependencies.
package bsp_pkg;

  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_SWEEP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  // one command as presented at the input
  typedef struct packed {
    op_t               operation;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [SLOT_W-1:0]  result_slot;
    status_t            status;
    logic [COUNT_W-1:0] used_slots;
    logic [COUNT_W-1:0] freed_slots;
    logic               pool_empty;
  } res_t;

  // classified command held in the queue
  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic              in_range;
  } q_ent_t;

  // queue head, front to back
  typedef struct packed {
    logic   avail;
    q_ent_t ent;
  } head_t;

  // back to front
  typedef struct packed {
    logic pop;
    logic clearing;
  } ctl_t;

endpackage

// ===== src/bsp_front.sv =====
// Front end of the slot pool: takes commands, range-checks the slot and queues them.
// Depends on bsp_pkg.
module bsp_front #(
  parameter int POOL_SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bsp_pkg::cmd_t cmd,
  input  bsp_pkg::ctl_t ctl,
  output logic          busy,
  output bsp_pkg::head_t head
);

  localparam int DEPTH = 2;

  bsp_pkg::q_ent_t q [DEPTH];
  bsp_pkg::q_ent_t ent_in;
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic            push;

  assign busy = (cnt == 2'(DEPTH)) || ctl.clearing;
  assign push = start && !busy;

  always_comb begin
    ent_in.op       = cmd.operation;
    ent_in.slot     = cmd.slot_index;
    ent_in.in_range = (32'(cmd.slot_index) < POOL_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (ctl.pop) begin
        rp <= ~rp;
      end
      case ({push, ctl.pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= ent_in;
    end
  end

  assign head.avail = (cnt != 2'd0);
  assign head.ent   = q[rp];

endmodule

// ===== src/bsp_back.sv =====
// Back end of the slot pool: bitmap memories, used count and the sequencer that
// runs allocate, release, mark and sweep word by word. Depends on bsp_pkg.
module bsp_back #(
  parameter int POOL_SLOTS = 256,
  parameter int WORD_BITS  = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  bsp_pkg::head_t head,
  output bsp_pkg::ctl_t  ctl,
  output logic           done,
  output bsp_pkg::res_t  result
);

  localparam int WORD_COUNT = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int CW         = $clog2(POOL_SLOTS + 1);
  localparam int XW         = CW + bsp_pkg::SLOT_W;
  localparam int LAST_BITS  = POOL_SLOTS - (WORD_COUNT - 1) * WORD_BITS;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_TRY,
    S_SCAN,
    S_UPDATE,
    S_SWEEP
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   clr, clr_next;
  logic [AW-1:0]   word, word_next;
  bsp_pkg::q_ent_t cur, cur_next;
  logic [CW-1:0]   used, used_next;
  logic [CW-1:0]   freed, freed_next;
  logic            done_next;
  bsp_pkg::res_t   result_next;

  logic [WORD_BITS-1:0] use_mem  [WORD_COUNT];
  logic [WORD_BITS-1:0] mark_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] use_q, mark_q;
  logic [WORD_BITS-1:0] wd_use, wd_mark;
  logic [AW-1:0]        ra, wa;
  logic                 we_use, we_mark;

  // slot decoding (word size is a power of two)
  logic [XW-1:0]        cur_x, head_x, used_x;
  logic [AW-1:0]        cur_word, head_word, used_word;
  logic [WORD_BITS-1:0] cur_sel, used_sel;

  assign cur_x     = XW'(cur.slot);
  assign head_x    = XW'(head.ent.slot);
  assign used_x    = XW'(used);
  assign cur_word  = AW'(cur_x >> BW);
  assign head_word = AW'(head_x >> BW);
  assign used_word = AW'(used_x >> BW);
  assign cur_sel   = WORD_BITS'(1) << cur_x[BW-1:0];
  assign used_sel  = WORD_BITS'(1) << used_x[BW-1:0];

  // per-word helpers: valid lanes, lowest free bit, count of in-use unmarked slots
  logic [WORD_BITS-1:0] vmask, free_bits, first_sel;
  logic [BW-1:0]        first_bit;
  logic [BW:0]          drop;

  always_comb begin
    first_bit = '0;
    drop      = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      vmask[b] = (word != LAST_WORD) || (b < LAST_BITS);
    end
    free_bits = ~use_q & vmask;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        first_bit = BW'(b);
      end
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      drop = drop + (BW + 1)'(use_q[b] & ~mark_q[b]);
    end
    first_sel = WORD_BITS'(1) << first_bit;
  end

  always_comb begin
    logic                     emit;
    logic [XW-1:0]            emit_slot;
    bsp_pkg::status_t         emit_status;
    logic [CW-1:0]            emit_freed;
    logic [XW-1:0]            freed_sum;

    emit        = 1'b0;
    emit_slot   = '0;
    emit_status = bsp_pkg::ST_OK;
    emit_freed  = '0;
    freed_sum   = XW'(freed) + XW'(drop);

    state_next  = state;
    clr_next    = clr;
    word_next   = word;
    cur_next    = cur;
    used_next   = used;
    freed_next  = freed;
    done_next   = 1'b0;
    result_next = result;
    ctl.pop     = 1'b0;
    ctl.clearing = (state == S_CLEAR);
    ra          = '0;
    wa          = '0;
    we_use      = 1'b0;
    we_mark     = 1'b0;
    wd_use      = use_q;
    wd_mark     = mark_q;

    case (state)
      S_CLEAR: begin
        wa       = clr;
        we_use   = 1'b1;
        we_mark  = 1'b1;
        wd_use   = '0;
        wd_mark  = '0;
        clr_next = clr + AW'(1);
        if (clr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.avail) begin
          ctl.pop  = 1'b1;
          cur_next = head.ent;
          case (head.ent.op)
            bsp_pkg::OP_ALLOC: begin
              if (32'(used) < POOL_SLOTS) begin
                ra         = used_word;
                state_next = S_ALLOC_TRY;
              end else begin
                word_next  = '0;
                state_next = S_SCAN;
              end
            end
            bsp_pkg::OP_RELEASE, bsp_pkg::OP_MARK: begin
              if (head.ent.in_range) begin
                ra         = head_word;
                state_next = S_UPDATE;
              end else begin
                emit        = 1'b1;
                emit_slot   = head_x;
                emit_status = bsp_pkg::ST_NOT_USED;
              end
            end
            default: begin
              word_next  = '0;
              freed_next = '0;
              state_next = S_SWEEP;
            end
          endcase
        end
      end
      S_ALLOC_TRY: begin
        if ((use_q & used_sel) == '0) begin
          wa         = used_word;
          we_use     = 1'b1;
          we_mark    = 1'b1;
          wd_use     = use_q | used_sel;
          wd_mark    = mark_q & ~used_sel;
          used_next  = used + CW'(1);
          emit       = 1'b1;
          emit_slot  = used_x;
          state_next = S_IDLE;
        end else begin
          word_next  = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          wa         = word;
          we_use     = 1'b1;
          we_mark    = 1'b1;
          wd_use     = use_q | first_sel;
          wd_mark    = mark_q & ~first_sel;
          used_next  = used + CW'(1);
          emit       = 1'b1;
          emit_slot  = (XW'(word) << BW) | XW'(first_bit);
          state_next = S_IDLE;
        end else if (word == LAST_WORD) begin
          emit        = 1'b1;
          emit_status = bsp_pkg::ST_FULL;
          state_next  = S_IDLE;
        end else begin
          word_next = word + AW'(1);
          ra        = word + AW'(1);
        end
      end
      S_UPDATE: begin
        emit       = 1'b1;
        emit_slot  = cur_x;
        state_next = S_IDLE;
        wa         = cur_word;
        if ((use_q & cur_sel) == '0) begin
          emit_status = bsp_pkg::ST_NOT_USED;
        end else if (cur.op == bsp_pkg::OP_RELEASE) begin
          we_use    = 1'b1;
          we_mark   = 1'b1;
          wd_use    = use_q & ~cur_sel;
          wd_mark   = mark_q & ~cur_sel;
          used_next = used - CW'(1);
        end else begin
          we_mark = 1'b1;
          wd_mark = mark_q | cur_sel;
        end
      end
      S_SWEEP: begin
        // survivors are exactly the marked slots, marks never sit on free slots
        wa         = word;
        we_use     = 1'b1;
        we_mark    = 1'b1;
        wd_use     = use_q & mark_q;
        wd_mark    = '0;
        used_next  = used - CW'(drop);
        freed_next = CW'(freed_sum);
        if (word == LAST_WORD) begin
          emit       = 1'b1;
          emit_freed = CW'(freed_sum);
          state_next = S_IDLE;
        end else begin
          word_next = word + AW'(1);
          ra        = word + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      done_next               = 1'b1;
      result_next.result_slot = bsp_pkg::SLOT_W'(emit_slot);
      result_next.status      = emit_status;
      result_next.used_slots  = bsp_pkg::COUNT_W'(used_next);
      result_next.freed_slots = bsp_pkg::COUNT_W'(emit_freed);
      result_next.pool_empty  = (used_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      word  <= '0;
      used  <= '0;
      freed <= '0;
      done  <= 1'b0;
    end else begin
      state  <= state_next;
      clr    <= clr_next;
      word   <= word_next;
      used   <= used_next;
      freed  <= freed_next;
      done   <= done_next;
      cur    <= cur_next;
      result <= result_next;
    end
  end

  // bitmap memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (we_use) begin
      use_mem[wa] <= wd_use;
    end
    if (we_mark) begin
      mark_mem[wa] <= wd_mark;
    end
    use_q  <= use_mem[ra];
    mark_q <= mark_mem[ra];
  end

`ifndef SYNTHESIS
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.pool_empty == (used == '0)))
    else $error("pool_empty disagrees with used count");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == bsp_pkg::ST_FULL) |-> (32'(used) == POOL_SLOTS))
    else $error("full reported with free slots left");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= POOL_SLOTS)
    else $error("used count beyond pool size");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (state == S_IDLE && head.avail))
    else $error("queue popped outside idle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !done)
    else $error("result during clearing pass");
`endif

endmodule

// ===== src/bitmap_slot_pool_mark_sweep_core.sv =====
// Flow: an accepted start is queued; in-range release and mark and an allocate hitting the
//   count-numbered slot read one bitmap word and answer; a missed allocate scans one bitmap word
//   a cycle from word 0, and sweep walks every word once. Commands queue while the back end is busy.
// The back-end sequencer handles one command at a time, with a single read port per bitmap memory.
// Reset (synchronous, rst high) starts a clearing pass over all WORD_COUNT words, busy held high.
// Results are strobed for one cycle on done; the receiver cannot stall.
module bitmap_slot_pool_mark_sweep_core #(
  parameter int POOL_SLOTS = 256,  // 32 .. 256
  parameter int WORD_BITS  = 32    // bitmap word size, a power of two, 8 .. 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bsp_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output bsp_pkg::res_t result
);

  // Front: two-entry command queue; a transfer lands there while the back end
  // is still busy with an earlier command.
  bsp_pkg::head_t head;
  bsp_pkg::ctl_t  ctl;

  bsp_front #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .ctl   (ctl),
    .busy  (busy),
    .head  (head)
  );

  // Back: in-use and mark bitmaps held as memories of WORD_BITS-wide words,
  // walked one word per cycle for the free-slot search and the sweep.
  bsp_back #(
    .POOL_SLOTS (POOL_SLOTS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .ctl    (ctl),
    .done   (done),
    .result (result)
  );

endmodule

// ===== sim/bitmap_slot_pool_mark_sweep_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_slot_pool_mark_sweep_core: a directed table, then random
// allocate/release/mark/sweep traffic scored against an in-bench pool predictor.
// Depends on bsp_pkg (src/bsp_pkg.sv) and the core RTL; reads no files.
module bitmap_slot_pool_mark_sweep_core_tb;

  localparam int SLOTS        = 256;
  localparam int ITEMS        = 850;
  localparam int PLAN_LEN     = 22;
  localparam int DRAIN_CYCLES = 24;  // idle margin after the last expected result
  localparam logic [bsp_pkg::COUNT_W-1:0] FULL = bsp_pkg::COUNT_W'(SLOTS);

  // one row of the directed table; want is only used where fixed is set
  typedef struct {
    bsp_pkg::op_t               op;
    logic [bsp_pkg::SLOT_W-1:0] slot;
    bit                         fixed;
    bsp_pkg::res_t              want;
  } step_t;

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  bsp_pkg::cmd_t cmd   = '0;
  logic          busy;
  logic          done;
  bsp_pkg::res_t result;

  // predictor state: in-use bitmap, mark bitmap, used count
  logic [SLOTS-1:0]            live_map   = '0;
  logic [SLOTS-1:0]            mark_map   = '0;
  logic [bsp_pkg::COUNT_W-1:0] live_count = '0;

  bsp_pkg::res_t pending_results[$];
  int            errors     = 0;
  int            issued     = 0;
  int            burst_left = 0;

  // Directed part, starting from the reset state. Rows with fixed set carry the answer
  // by hand (empty pool, first allocations, double release); the rest go to the predictor.
  step_t plan [PLAN_LEN] = '{
    '{bsp_pkg::OP_RELEASE, 8'h00, 1'b1, '{8'h00, bsp_pkg::ST_NOT_USED, 9'd0, 9'd0, 1'b1}},
    '{bsp_pkg::OP_MARK,    8'hFF, 1'b1, '{8'hFF, bsp_pkg::ST_NOT_USED, 9'd0, 9'd0, 1'b1}},
    '{bsp_pkg::OP_SWEEP,   8'h55, 1'b1, '{8'h00, bsp_pkg::ST_OK,       9'd0, 9'd0, 1'b1}},
    '{bsp_pkg::OP_ALLOC,   8'hAA, 1'b1, '{8'h00, bsp_pkg::ST_OK,       9'd1, 9'd0, 1'b0}},
    '{bsp_pkg::OP_ALLOC,   8'hFF, 1'b1, '{8'h01, bsp_pkg::ST_OK,       9'd2, 9'd0, 1'b0}},
    '{bsp_pkg::OP_ALLOC,   8'h00, 1'b1, '{8'h02, bsp_pkg::ST_OK,       9'd3, 9'd0, 1'b0}},
    '{bsp_pkg::OP_RELEASE, 8'h01, 1'b1, '{8'h01, bsp_pkg::ST_OK,       9'd2, 9'd0, 1'b0}},
    '{bsp_pkg::OP_RELEASE, 8'h01, 1'b1, '{8'h01, bsp_pkg::ST_NOT_USED, 9'd2, 9'd0, 1'b0}},
    '{bsp_pkg::OP_ALLOC,   8'h55, 1'b0, '0},  // count-numbered slot taken: lowest free instead
    '{bsp_pkg::OP_ALLOC,   8'hAA, 1'b0, '0},
    '{bsp_pkg::OP_MARK,    8'h00, 1'b0, '0},
    '{bsp_pkg::OP_MARK,    8'h03, 1'b0, '0},
    '{bsp_pkg::OP_MARK,    8'hC8, 1'b0, '0},  // mark of a free slot
    '{bsp_pkg::OP_SWEEP,   8'hFF, 1'b0, '0},  // frees the unmarked, clears survivors' marks
    '{bsp_pkg::OP_SWEEP,   8'h00, 1'b0, '0},  // now the survivors go too
    '{bsp_pkg::OP_ALLOC,   8'h00, 1'b0, '0},
    '{bsp_pkg::OP_MARK,    8'h00, 1'b0, '0},
    '{bsp_pkg::OP_RELEASE, 8'h00, 1'b0, '0},  // release drops the mark as well
    '{bsp_pkg::OP_ALLOC,   8'hFF, 1'b0, '0},
    '{bsp_pkg::OP_SWEEP,   8'h55, 1'b0, '0},
    '{bsp_pkg::OP_RELEASE, 8'hAA, 1'b0, '0},
    '{bsp_pkg::OP_MARK,    8'h55, 1'b0, '0}
  };

  bitmap_slot_pool_mark_sweep_core #(
    .POOL_SLOTS(SLOTS),
    .WORD_BITS (32)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #6 clk = ~clk;

  // Pool predictor: applies one accepted command to the local state, returns the result.
  function automatic bsp_pkg::res_t pool_apply(input bsp_pkg::cmd_t c);
    bsp_pkg::res_t r;
    bit            hit;
    r        = '0;
    r.status = bsp_pkg::ST_OK;
    hit      = 1'b0;
    case (c.operation)
      bsp_pkg::OP_ALLOC: begin
        if (live_count < FULL && !live_map[live_count[bsp_pkg::SLOT_W-1:0]]) begin
          r.result_slot = live_count[bsp_pkg::SLOT_W-1:0];
          hit           = 1'b1;
        end else begin
          for (int s = 0; s < SLOTS && !hit; s++) begin
            if (!live_map[s]) begin
              r.result_slot = s[bsp_pkg::SLOT_W-1:0];
              hit           = 1'b1;
            end
          end
        end
        if (hit) begin
          live_map[r.result_slot] = 1'b1;
          mark_map[r.result_slot] = 1'b0;
          live_count              = live_count + 1'b1;
        end else begin
          r.result_slot = '0;
          r.status      = bsp_pkg::ST_FULL;
        end
      end
      bsp_pkg::OP_RELEASE: begin
        r.result_slot = c.slot_index;
        if (live_map[c.slot_index]) begin
          live_map[c.slot_index] = 1'b0;
          mark_map[c.slot_index] = 1'b0;
          if (live_count != 0) live_count = live_count - 1'b1;
        end else begin
          r.status = bsp_pkg::ST_NOT_USED;
        end
      end
      bsp_pkg::OP_MARK: begin
        r.result_slot = c.slot_index;
        if (live_map[c.slot_index]) mark_map[c.slot_index] = 1'b1;
        else r.status = bsp_pkg::ST_NOT_USED;
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (live_map[s]) begin
            if (mark_map[s]) begin
              mark_map[s] = 1'b0;
            end else begin
              live_map[s] = 1'b0;
              if (live_count != 0) live_count = live_count - 1'b1;
              r.freed_slots = r.freed_slots + 1'b1;
            end
          end
        end
      end
    endcase
    r.used_slots = live_count;
    r.pool_empty = (live_count == 0);
    return r;
  endfunction

  // some in-use slot, scanning from a random point; any slot if the pool is empty
  function automatic logic [bsp_pkg::SLOT_W-1:0] pick_live_slot();
    bit [31:0] base;
    bit [31:0] probe;
    base = $urandom_range(SLOTS - 1, 0);
    for (int i = 0; i < SLOTS; i++) begin
      probe = (base + i) % SLOTS;
      if (live_map[probe[bsp_pkg::SLOT_W-1:0]]) return probe[bsp_pkg::SLOT_W-1:0];
    end
    return base[bsp_pkg::SLOT_W-1:0];
  endfunction

  // Weights in percent; whatever is left over goes to sweep. Releases and marks mostly
  // target live slots so they get past the not-in-use check; a quarter are noise.
  function automatic bsp_pkg::cmd_t draw_cmd(input int w_alloc, input int w_release,
                                             input int w_mark);
    bsp_pkg::cmd_t c;
    bit [31:0]     rnd;
    int            roll;
    rnd          = $urandom;
    roll         = $urandom_range(99, 0);
    c.slot_index = rnd[bsp_pkg::SLOT_W-1:0];
    if (roll < w_alloc) c.operation = bsp_pkg::OP_ALLOC;
    else if (roll < w_alloc + w_release) c.operation = bsp_pkg::OP_RELEASE;
    else if (roll < w_alloc + w_release + w_mark) c.operation = bsp_pkg::OP_MARK;
    else c.operation = bsp_pkg::OP_SWEEP;
    if ((c.operation == bsp_pkg::OP_RELEASE || c.operation == bsp_pkg::OP_MARK) &&
        $urandom_range(3, 0) != 0)
      c.slot_index = pick_live_slot();
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // One command transfer. The sender runs in bursts; between bursts start drops for a
  // random gap. Prediction happens at the accepting edge, so the state is current for
  // the next draw.
  task automatic send(input bsp_pkg::cmd_t c, input bit fixed, input bsp_pkg::res_t want);
    bsp_pkg::res_t predicted;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(7, 0) == 0) ? 60 : $urandom_range(12, 1);
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    predicted = pool_apply(c);
    pending_results.push_back(fixed ? want : predicted);
    issued++;
  endtask

  // Result side: done is a one-cycle strobe, no back-pressure possible.
  always @(posedge clk) begin
    bsp_pkg::res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (slot %0d status %0d)",
                                  result.result_slot, result.status));
      end else begin
        want = pending_results.pop_front();
        if (result.result_slot !== want.result_slot)
          report_mismatch($sformatf("result_slot %0d, want %0d",
                                    result.result_slot, want.result_slot));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
                                    result.status, want.status, want.result_slot));
        if (result.used_slots !== want.used_slots)
          report_mismatch($sformatf("used_slots %0d, want %0d",
                                    result.used_slots, want.used_slots));
        if (result.freed_slots !== want.freed_slots)
          report_mismatch($sformatf("freed_slots %0d, want %0d",
                                    result.freed_slots, want.freed_slots));
        if (result.pool_empty !== want.pool_empty)
          report_mismatch($sformatf("pool_empty %0b, want %0b",
                                    result.pool_empty, want.pool_empty));
      end
    end
  end

  initial begin
    bsp_pkg::cmd_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;  // busy stays high through the clearing pass; send waits on it

    foreach (plan[i]) begin
      c.operation  = plan[i].op;
      c.slot_index = plan[i].slot;
      send(c, plan[i].fixed, plan[i].want);
    end

    // general mix, pool stays fairly small
    repeat (150) send(draw_cmd(35, 25, 35), 1'b0, '0);

    // fill to the brim with no marks, then knock on the full pool
    while (live_count != FULL) send(draw_cmd(100, 0, 0), 1'b0, '0);
    repeat (6) send(draw_cmd(100, 0, 0), 1'b0, '0);

    // punch holes and refill them: allocate misses its count slot and hunts the lowest hole
    repeat (20) begin
      send(draw_cmd(0, 100, 0), 1'b0, '0);
      send(draw_cmd(100, 0, 0), 1'b0, '0);
    end

    // sweep: frees every in-use slot not still marked from the general mix
    send(draw_cmd(0, 0, 0), 1'b0, '0);

    // refill with marks sprinkled in, mark a batch, then two sweeps to clear survivors
    while (live_count < bsp_pkg::COUNT_W'(200)) send(draw_cmd(80, 5, 15), 1'b0, '0);
    repeat (60) send(draw_cmd(0, 0, 100), 1'b0, '0);
    repeat (2) send(draw_cmd(0, 0, 0), 1'b0, '0);

    while (issued < ITEMS) send(draw_cmd(30, 25, 35), 1'b0, '0);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bitmap_slot_pool_mark_sweep_core_tb: PASS");
    end else begin
      $display("bitmap_slot_pool_mark_sweep_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog against a hung run
  initial begin
    #2_000_000;
    $display("bitmap_slot_pool_mark_sweep_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bsp_pkg.sv
src/bsp_front.sv
src/bsp_back.sv
src/bitmap_slot_pool_mark_sweep_core.sv
sim/bitmap_slot_pool_mark_sweep_core_tb.sv
